[sv/cartesian_to_frenet_top_macros.svh]
`ifndef CARTESIAN_TO_FRENET_TOP_MACROS_SVH
`define CARTESIAN_TO_FRENET_TOP_MACROS_SVH

// property checked at every clock edge outside reset
`define CTF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in one cycle implies consequence in the next
`define CTF_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

[sv/ctf_pkg.sv]
`default_nettype none
package ctf_pkg;
	localparam int MAX_WAYPOINTS = 8192;
	localparam int IDX_W = $clog2(MAX_WAYPOINTS);
	localparam int CNT_W = IDX_W + 1;
	localparam int S_W = 31;
	localparam int WORD_W = 32 + 32 + S_W;
	localparam int CW = 36;
	localparam int ANG_W = 24;
	localparam int ANG_ITERS = 17;
	localparam int PROJ_ITERS = 34;
	localparam int IT_W = 6;
	localparam int MAG_W = 25;
	localparam int SQ_W = 2 * MAG_W + 1;
	localparam int HALF_W = 18;
	localparam int PROD_W = HALF_W + 30;
	localparam int ACC_W = 66;
	localparam logic [32:0] NEAR_LIMIT = 33'd25600000;
	localparam logic [SQ_W-1:0] BEST2_INIT = SQ_W'(64'd655360000000000);
	localparam logic [29:0] INV_GAIN = 30'd652032874;
	localparam logic [ANG_W-1:0] HALF_TURN = 24'h800000;
	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WAYPOINTS);

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [1:0] {
		REG_COUNT = 2'd0,
		REG_CENTER_X = 2'd1,
		REG_CENTER_Y = 2'd2
	} cfg_reg_t;

	// shift toward zero
	function automatic logic signed [CW-1:0] tshr(input logic signed [CW-1:0] v,
			input logic [IT_W-1:0] k);
		logic signed [CW-1:0] neg;
		neg = -v;
		if (v >= 0) begin
			return v >>> k;
		end
		return -(neg >>> k);
	endfunction

	function automatic logic [ANG_W-1:0] atan_lut(input logic [IT_W-1:0] i);
		case (i)
			6'd0: return 24'd2097152;
			6'd1: return 24'd1238021;
			6'd2: return 24'd654136;
			6'd3: return 24'd332050;
			6'd4: return 24'd166669;
			6'd5: return 24'd83416;
			6'd6: return 24'd41718;
			6'd7: return 24'd20860;
			6'd8: return 24'd10430;
			6'd9: return 24'd5215;
			6'd10: return 24'd2608;
			6'd11: return 24'd1304;
			6'd12: return 24'd652;
			6'd13: return 24'd326;
			6'd14: return 24'd163;
			6'd15: return 24'd81;
			6'd16: return 24'd41;
			default: return '0;
		endcase
	endfunction
endpackage
`default_nettype wire

[sv/ctf_if.sv]
`default_nettype none
interface ctf_req_if;
	logic valid;
	logic ready;
	logic action;
	logic [12:0] entry_index;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [30:0] arc_pos;
	logic [15:0] heading;
	modport source(output valid, action, entry_index, pos_x, pos_y, arc_pos, heading,
		input ready);
	modport sink(input valid, action, entry_index, pos_x, pos_y, arc_pos, heading,
		output ready);
endinterface

interface ctf_rsp_if;
	logic valid;
	logic ready;
	logic [30:0] track_s;
	logic signed [31:0] track_d;
	logic [12:0] next_index;
	modport source(output valid, track_s, track_d, next_index, input ready);
	modport sink(input valid, track_s, track_d, next_index, output ready);
endinterface
`default_nettype wire

[sv/ctf_ram.sv]
`default_nettype none
module ctf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

[sv/cartesian_to_frenet_top.sv]
// channel  dir  handshake     payload
// req      in   valid/ready   action, entry_index, pos_x, pos_y, arc_pos, heading
// rsp      out  valid/ready   track_s, track_d, next_index
// cfg      in   cfg_we        cfg_index, cfg_data
//
// a load request is one write into the waypoint ram
// a query includes one ram read per waypoint for the nearest search,
// 17 angle cordic steps, 34 projection cordic steps and 4 partial products
// req.ready is high only while the sequencer is idle; rsp has its own output register
// so a result waiting on rsp.ready stalls only the last step of the following query
// arst_n clears control state; ram contents are undefined until written
`default_nettype none
`include "cartesian_to_frenet_top_macros.svh"
module cartesian_to_frenet_top
	import ctf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data,
	ctf_req_if.sink req,
	ctf_rsp_if.source rsp
);
	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_SCAN = 13'b0000000000010,
		S_RD_BEST = 13'b0000000000100,
		S_ANG_INIT = 13'b0000000001000,
		S_ANG = 13'b0000000010000,
		S_DECIDE = 13'b0000000100000,
		S_RD_NEXT = 13'b0000001000000,
		S_RD_PREV = 13'b0000010000000,
		S_PROJ_INIT = 13'b0000100000000,
		S_PROJ = 13'b0001000000000,
		S_MUL = 13'b0010000000000,
		S_RND = 13'b0100000000000,
		S_FIN = 13'b1000000000000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [31:0] cx_q, cy_q, px_q, py_q;
	logic [15:0] hd_q;

	logic ram_we;
	logic [IDX_W-1:0] ram_addr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;
	logic signed [31:0] rd_x, rd_y;
	logic [S_W-1:0] rd_s;

	logic [CNT_W-1:0] issue_q;
	logic v_s1, v_s2, v_s3, ok_s2, ok_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic [MAG_W-1:0] mx_s2, my_s2;
	logic [2*MAG_W-1:0] sqx_s3, sqy_s3;
	logic [IDX_W-1:0] best_q;
	logic [SQ_W-1:0] best2_q;

	logic signed [CW-1:0] rx_q, ry_q, v0x_q, v0y_q, v1x_q, v1y_q;
	logic [ANG_W-1:0] acc_q;
	logic [IT_W-1:0] iter_q;
	logic zero_q, degen_q;
	logic [IDX_W-1:0] next_q, prev_idx;
	logic signed [31:0] nwx_q, nwy_q;
	logic [S_W-1:0] ps_q;

	logic [2:0] ph_q;
	logic pv_s1;
	logic [1:0] ptag_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [ACC_W-1:0] along_acc_q, dm_acc_q;
	logic [CW-1:0] along_q, dm_q;
	logic neg_q;

	logic rsp_valid_q;
	logic [S_W-1:0] os_q;
	logic [31:0] od_q;
	logic [IDX_W-1:0] on_q;

	logic in_acc, out_free;

	assign req.ready = (state_q == S_IDLE);
	assign in_acc = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.track_s = os_q;
	assign rsp.track_d = od_q;
	assign rsp.next_index = on_q;

	assign rd_x = ram_rdata[31:0];
	assign rd_y = ram_rdata[63:32];
	assign rd_s = ram_rdata[WORD_W-1:64];
	assign prev_idx = (next_q == '0) ? IDX_W'(cnt_q - CNT_W'(1)) : next_q - IDX_W'(1);

	always_comb begin
		ram_we = 1'b0;
		ram_addr = req.entry_index;
		ram_wdata = {req.arc_pos, req.pos_y, req.pos_x};
		unique case (state_q)
			S_IDLE: ram_we = in_acc && (req.action == ACT_LOAD);
			S_SCAN: ram_addr = issue_q[IDX_W-1:0];
			S_RD_BEST: ram_addr = best_q;
			S_RD_NEXT: ram_addr = next_q;
			S_RD_PREV: ram_addr = prev_idx;
			default: ram_addr = req.entry_index;
		endcase
	end

	ctf_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WAYPOINTS)) u_ram (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// configuration
	logic [CNT_W-1:0] cfg_cnt;
	assign cfg_cnt = cfg_data[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_RESET;
			cx_q <= '0;
			cy_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COUNT: begin
					if (cfg_cnt < CNT_RESET) cnt_q <= CNT_RESET;
					else if (cfg_cnt > CNT_MAX) cnt_q <= CNT_MAX;
					else cnt_q <= cfg_cnt;
				end
				REG_CENTER_X: cx_q <= cfg_data;
				REG_CENTER_Y: cy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// nearest search datapath
	logic signed [32:0] dx, dy;
	logic [32:0] mdx, mdy;
	logic [SQ_W-1:0] d2;
	assign dx = 33'(rd_x) - 33'(px_q);
	assign dy = 33'(rd_y) - 33'(py_q);
	assign mdx = (dx < 0) ? 33'(-dx) : 33'(dx);
	assign mdy = (dy < 0) ? 33'(-dy) : 33'(dy);
	assign d2 = SQ_W'(sqx_s3) + SQ_W'(sqy_s3);

	// shared cordic micro-rotation
	logic up;
	logic signed [CW-1:0] rx_n, ry_n, v0x_n, v0y_n, v1x_n, v1y_n;
	always_comb begin
		up = (ry_q >= 0);
		rx_n = up ? rx_q + tshr(ry_q, iter_q) : rx_q - tshr(ry_q, iter_q);
		ry_n = up ? ry_q - tshr(rx_q, iter_q) : ry_q + tshr(rx_q, iter_q);
		v0x_n = up ? v0x_q + tshr(v0y_q, iter_q) : v0x_q - tshr(v0y_q, iter_q);
		v0y_n = up ? v0y_q - tshr(v0x_q, iter_q) : v0y_q + tshr(v0x_q, iter_q);
		v1x_n = up ? v1x_q + tshr(v1y_q, iter_q) : v1x_q - tshr(v1y_q, iter_q);
		v1y_n = up ? v1y_q - tshr(v1x_q, iter_q) : v1y_q + tshr(v1x_q, iter_q);
	end

	// angle init
	logic signed [CW-1:0] bx, by;
	assign bx = CW'(rd_x) - CW'(px_q);
	assign by = CW'(rd_y) - CW'(py_q);

	// bearing decision
	logic [ANG_W-1:0] acc_rnd;
	logic [15:0] bearing, diff, diff_w;
	logic [CNT_W-1:0] best_inc;
	assign acc_rnd = acc_q + ANG_W'(128);
	assign bearing = zero_q ? 16'd0 : acc_rnd[ANG_W-1:8];
	assign diff = hd_q - bearing;
	assign diff_w = (diff > 16'd32768) ? 16'(-diff) : diff;
	assign best_inc = CNT_W'(best_q) + CNT_W'(1);

	// projection init
	logic signed [CW-1:0] nx, ny, p0x, p0y, p1x, p1y, r0x, r0y;
	logic pdeg, pflip;
	assign nx = CW'(nwx_q) - CW'(rd_x);
	assign ny = CW'(nwy_q) - CW'(rd_y);
	assign p0x = CW'(px_q) - CW'(rd_x);
	assign p0y = CW'(py_q) - CW'(rd_y);
	assign p1x = CW'(cx_q) - CW'(rd_x);
	assign p1y = CW'(cy_q) - CW'(rd_y);
	assign pdeg = (nx == 0) && (ny == 0);
	assign r0x = pdeg ? p0x : nx;
	assign r0y = pdeg ? p0y : ny;
	assign pflip = (r0x < 0);

	// lengths and sign of d
	logic signed [CW-1:0] a_val, c_val;
	logic signed [CW:0] c2;
	logic [CW-1:0] along_mag, a_mag;
	logic [HALF_W-1:0] mul_op;
	logic [ACC_W-1:0] prod_sh;
	assign a_val = degen_q ? v0x_q : v0y_q;
	assign c_val = degen_q ? v1x_q : v1y_q;
	assign c2 = (CW+1)'(c_val) <<< 1;
	assign along_mag = degen_q ? '0 : ((v0x_q < 0) ? CW'(-v0x_q) : CW'(v0x_q));
	assign a_mag = (a_val < 0) ? CW'(-a_val) : CW'(a_val);
	always_comb begin
		case (ph_q[1:0])
			2'd0: mul_op = along_mag[HALF_W-1:0];
			2'd1: mul_op = along_mag[CW-1:HALF_W];
			2'd2: mul_op = a_mag[HALF_W-1:0];
			default: mul_op = a_mag[CW-1:HALF_W];
		endcase
	end
	assign prod_sh = ptag_s1[0] ? (ACC_W'(prod_s1) << HALF_W) : ACC_W'(prod_s1);

	logic [ACC_W-1:0] along_r, dm_r;
	assign along_r = (along_acc_q + ACC_W'(64'd536870912)) >> 30;
	assign dm_r = (dm_acc_q + ACC_W'(64'd536870912)) >> 30;

	logic [CW:0] s_sum;
	assign s_sum = (CW+1)'(ps_q) + (CW+1)'(along_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issue_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			pv_s1 <= 1'b0;
			iter_q <= '0;
			ph_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_SCAN) && (issue_q < cnt_q);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			pv_s1 <= (state_q == S_MUL) && !ph_q[2];
			if (rsp.ready && !((state_q == S_FIN) && out_free)) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					issue_q <= '0;
					if (in_acc && (req.action == ACT_QUERY)) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (issue_q < cnt_q) issue_q <= issue_q + CNT_W'(1);
					else if (!v_s1 && !v_s2 && !v_s3) state_q <= S_RD_BEST;
				end
				S_RD_BEST: state_q <= S_ANG_INIT;
				S_ANG_INIT: begin
					iter_q <= '0;
					state_q <= S_ANG;
				end
				S_ANG: begin
					iter_q <= iter_q + IT_W'(1);
					if (iter_q == IT_W'(ANG_ITERS - 1)) state_q <= S_DECIDE;
				end
				S_DECIDE: state_q <= S_RD_NEXT;
				S_RD_NEXT: state_q <= S_RD_PREV;
				S_RD_PREV: state_q <= S_PROJ_INIT;
				S_PROJ_INIT: begin
					iter_q <= '0;
					state_q <= S_PROJ;
				end
				S_PROJ: begin
					iter_q <= iter_q + IT_W'(1);
					ph_q <= '0;
					if (iter_q == IT_W'(PROJ_ITERS - 1)) state_q <= S_MUL;
				end
				S_MUL: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q[2]) state_q <= S_RND;
				end
				S_RND: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		ok_s2 <= (mdx < NEAR_LIMIT) && (mdy < NEAR_LIMIT);
		mx_s2 <= mdx[MAG_W-1:0];
		my_s2 <= mdy[MAG_W-1:0];
		idx_s3 <= idx_s2;
		ok_s3 <= ok_s2;
		sqx_s3 <= mx_s2 * mx_s2;
		sqy_s3 <= my_s2 * my_s2;
		prod_s1 <= mul_op * INV_GAIN;
		ptag_s1 <= ph_q[1:0];

		if (in_acc) begin
			px_q <= req.pos_x;
			py_q <= req.pos_y;
			hd_q <= req.heading;
			best_q <= '0;
			best2_q <= BEST2_INIT;
		end
		if (v_s3 && ok_s3 && (d2 < best2_q)) begin
			best2_q <= d2;
			best_q <= idx_s3;
		end

		if (state_q == S_ANG_INIT) begin
			zero_q <= (bx == 0) && (by == 0);
			rx_q <= (bx < 0) ? -bx : bx;
			ry_q <= (bx < 0) ? -by : by;
			acc_q <= (bx < 0) ? HALF_TURN : '0;
		end
		if (state_q == S_ANG) begin
			rx_q <= rx_n;
			ry_q <= ry_n;
			acc_q <= up ? acc_q + atan_lut(iter_q) : acc_q - atan_lut(iter_q);
		end
		if (state_q == S_DECIDE) begin
			if (diff_w > 16'd8192) next_q <= (best_inc >= cnt_q) ? '0 : best_inc[IDX_W-1:0];
			else next_q <= best_q;
		end
		if (state_q == S_RD_PREV) begin
			nwx_q <= rd_x;
			nwy_q <= rd_y;
		end
		if (state_q == S_PROJ_INIT) begin
			ps_q <= rd_s;
			degen_q <= pdeg;
			rx_q <= pflip ? -r0x : r0x;
			ry_q <= pflip ? -r0y : r0y;
			v0x_q <= pflip ? -p0x : p0x;
			v0y_q <= pflip ? -p0y : p0y;
			v1x_q <= pflip ? -p1x : p1x;
			v1y_q <= pflip ? -p1y : p1y;
		end
		if (state_q == S_PROJ) begin
			rx_q <= rx_n;
			ry_q <= ry_n;
			v0x_q <= v0x_n;
			v0y_q <= v0y_n;
			v1x_q <= v1x_n;
			v1y_q <= v1y_n;
			along_acc_q <= '0;
			dm_acc_q <= '0;
		end
		if (state_q == S_MUL) begin
			neg_q <= (a_val == 0) || ((a_val > 0) && ((CW+1)'(a_val) <= c2)) ||
				((a_val < 0) && ((CW+1)'(a_val) >= c2));
			if (pv_s1) begin
				if (ptag_s1[1]) dm_acc_q <= dm_acc_q + prod_sh;
				else along_acc_q <= along_acc_q + prod_sh;
			end
		end
		if (state_q == S_RND) begin
			along_q <= along_r[CW-1:0];
			dm_q <= dm_r[CW-1:0];
		end
		if ((state_q == S_FIN) && out_free) begin
			os_q <= (s_sum > (CW+1)'(32'h7FFFFFFF)) ? 31'h7FFFFFFF : s_sum[S_W-1:0];
			if (neg_q) od_q <= (dm_q > CW'(32'h80000000)) ? 32'h80000000 : -dm_q[31:0];
			else od_q <= (dm_q > CW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : dm_q[31:0];
			on_q <= next_q;
		end
	end

	`CTF_ASSERT(a_we_idle, ram_we |-> (state_q == S_IDLE), "ram written outside idle")
	`CTF_ASSERT(a_best_range, (state_q == S_RD_BEST) |-> (CNT_W'(best_q) < cnt_q), "best out of range")
	`CTF_ASSERT(a_next_range, (state_q == S_RD_NEXT) |-> (CNT_W'(next_q) < cnt_q), "next out of range")
	`CTF_ASSERT_NEXT(a_fin_out, (state_q == S_FIN) && out_free, rsp_valid_q, "result not posted")
endmodule
`default_nettype wire
